FILE: design/gbw_pkg.sv
package gbw_pkg;

  localparam int NODES  = 64;
  localparam int NODE_W = 6;
  localparam int CNT_W  = 7;
  localparam int ADJ_AW = 2 * NODE_W;

  localparam logic [CNT_W-1:0] NODES_C = CNT_W'(NODES);

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_WALK  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic ST_OK        = 1'b0;
  localparam logic ST_BAD_START = 1'b1;

  localparam logic MODE_DEPTH = 1'b0;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic              walk_mode;
  } item_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] level;
    logic              last;
    logic              status;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LK_RD,
    S_LK_CHK,
    S_W_INIT,
    S_W_POP,
    S_W_NODE,
    S_W_DEG,
    S_W_ADJ_RD,
    S_W_ADJ_CHK
  } state_t;

  typedef struct packed {
    logic accept;
    logic clear_graph;
    logic emit_error;
    logic lk_rd;
    logic lk_chk;
    logic w_init;
    logic w_pop;
    logic w_node;
    logic w_deg;
    logic w_adj_rd;
    logic w_adj_chk;
  } ctrl_t;

  typedef struct packed {
    logic edge_ok;
    logic start_ok;
    logic second_pass;
    logic frontier_empty;
    logic adj_more;
  } stat_t;

endpackage

FILE: design/gbw_ctrl.sv
module gbw_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [1:0]     cmd,
  input  gbw_pkg::stat_t stat,
  output gbw_pkg::ctrl_t ctrl,
  output logic           busy
);

  gbw_pkg::state_t state;
  gbw_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbw_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      gbw_pkg::S_IDLE: begin
        if (start) begin
          if (cmd == gbw_pkg::CMD_LOAD && stat.edge_ok) begin
            state_next = gbw_pkg::S_LK_RD;
          end else if (cmd == gbw_pkg::CMD_WALK && stat.start_ok) begin
            state_next = gbw_pkg::S_W_INIT;
          end
        end
      end
      gbw_pkg::S_LK_RD:  state_next = gbw_pkg::S_LK_CHK;
      gbw_pkg::S_LK_CHK: state_next = stat.second_pass ? gbw_pkg::S_IDLE : gbw_pkg::S_LK_RD;
      gbw_pkg::S_W_INIT: state_next = gbw_pkg::S_W_POP;
      gbw_pkg::S_W_POP:  state_next = stat.frontier_empty ? gbw_pkg::S_IDLE : gbw_pkg::S_W_NODE;
      gbw_pkg::S_W_NODE: state_next = gbw_pkg::S_W_DEG;
      gbw_pkg::S_W_DEG:  state_next = gbw_pkg::S_W_ADJ_RD;
      gbw_pkg::S_W_ADJ_RD: begin
        state_next = stat.adj_more ? gbw_pkg::S_W_ADJ_CHK : gbw_pkg::S_W_POP;
      end
      gbw_pkg::S_W_ADJ_CHK: state_next = gbw_pkg::S_W_ADJ_RD;
      default: state_next = gbw_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    busy = 1'b1;
    case (state)
      gbw_pkg::S_IDLE: begin
        busy             = 1'b0;
        ctrl.accept      = start;
        ctrl.clear_graph = start && (cmd == gbw_pkg::CMD_CLEAR);
        ctrl.emit_error  = start && (cmd == gbw_pkg::CMD_WALK) && !stat.start_ok;
      end
      gbw_pkg::S_LK_RD:     ctrl.lk_rd     = 1'b1;
      gbw_pkg::S_LK_CHK:    ctrl.lk_chk    = 1'b1;
      gbw_pkg::S_W_INIT:    ctrl.w_init    = 1'b1;
      gbw_pkg::S_W_POP:     ctrl.w_pop     = 1'b1;
      gbw_pkg::S_W_NODE:    ctrl.w_node    = 1'b1;
      gbw_pkg::S_W_DEG:     ctrl.w_deg     = 1'b1;
      gbw_pkg::S_W_ADJ_RD:  ctrl.w_adj_rd  = 1'b1;
      gbw_pkg::S_W_ADJ_CHK: ctrl.w_adj_chk = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

FILE: design/gbw_dp.sv
module gbw_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  gbw_pkg::item_t        item,
  input  logic                  cfg_valid,
  input  logic [gbw_pkg::CNT_W-1:0] cfg_data,
  input  gbw_pkg::ctrl_t        ctrl,
  output gbw_pkg::stat_t        stat,
  output gbw_pkg::result_t      result,
  output logic                  result_valid
);

  localparam int NW = gbw_pkg::NODE_W;
  localparam int CW = gbw_pkg::CNT_W;

  // Stores; the valid bits stand in for the zero reset of degrees and edge rows.
  logic [NW-1:0]             adj_mem [gbw_pkg::NODES*gbw_pkg::NODES];
  logic [CW-1:0]             deg_mem [gbw_pkg::NODES];
  logic [gbw_pkg::NODES-1:0] edge_mem [gbw_pkg::NODES];
  logic [2*NW-1:0]           front_mem [gbw_pkg::NODES];
  logic [gbw_pkg::NODES-1:0] deg_vld;
  logic [gbw_pkg::NODES-1:0] edge_vld;

  logic [NW-1:0]             adj_q;
  logic [CW-1:0]             deg_q;
  logic [gbw_pkg::NODES-1:0] edge_q;
  logic [2*NW-1:0]           front_q;

  logic [CW-1:0]             node_count;
  logic [NW-1:0]             lk_from;
  logic [NW-1:0]             lk_to;
  logic                      second_pass;
  logic                      mode;
  logic [gbw_pkg::NODES-1:0] visited;
  logic [CW-1:0]             head;
  logic [CW-1:0]             tail;
  logic [NW-1:0]             cur_node;
  logic [NW-1:0]             cur_lev;
  logic                      pend_valid;
  logic [CW-1:0]             deg_r;
  logic [CW-1:0]             idx;

  logic [CW-1:0]             lim;
  logic [NW-1:0]             deg_addr;
  logic [NW-1:0]             front_raddr;
  logic [CW-1:0]             tail_dec;
  logic [gbw_pkg::NODES-1:0] row_eff;
  logic [CW-1:0]             deg_eff;
  logic                      link_go;
  logic                      push_go;

  assign lim = (node_count > gbw_pkg::NODES_C) ? gbw_pkg::NODES_C : node_count;

  assign stat.edge_ok  = ({1'b0, item.node_a} < lim) && ({1'b0, item.node_b} < lim);
  assign stat.start_ok = ({1'b0, item.node_a} < lim);
  assign stat.second_pass    = second_pass;
  assign stat.frontier_empty = (tail <= head);
  assign stat.adj_more       = (idx < deg_r);

  assign tail_dec    = tail - CW'(1);
  assign front_raddr = (mode == gbw_pkg::MODE_DEPTH) ? tail_dec[NW-1:0] : head[NW-1:0];
  assign deg_addr    = ctrl.lk_rd ? lk_from : front_q[2*NW-1:NW];

  assign row_eff = edge_vld[lk_from] ? edge_q : '0;
  assign deg_eff = deg_vld[lk_from] ? deg_q : '0;
  assign link_go = ctrl.lk_chk && !row_eff[lk_to] && (deg_eff < gbw_pkg::NODES_C);
  assign push_go = ctrl.w_adj_chk && !visited[adj_q] && (tail < gbw_pkg::NODES_C);

  always_ff @(posedge clk) begin
    adj_q   <= adj_mem[{cur_node, idx[NW-1:0]}];
    deg_q   <= deg_mem[deg_addr];
    edge_q  <= edge_mem[lk_from];
    front_q <= front_mem[front_raddr];
    if (link_go) begin
      adj_mem[{lk_from, deg_eff[NW-1:0]}] <= lk_to;
      deg_mem[lk_from]  <= deg_eff + CW'(1);
      edge_mem[lk_from] <= row_eff | (gbw_pkg::NODES'(1) << lk_to);
    end
    if (ctrl.w_init) begin
      front_mem[0] <= {lk_from, {NW{1'b0}}};
    end else if (push_go) begin
      front_mem[tail[NW-1:0]] <= {adj_q, (mode == gbw_pkg::MODE_DEPTH) ? {NW{1'b0}}
                                                                   : cur_lev + NW'(1)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count   <= gbw_pkg::NODES_C;
      deg_vld      <= '0;
      edge_vld     <= '0;
      result_valid <= 1'b0;
      pend_valid   <= 1'b0;
      head         <= '0;
      tail         <= '0;
      second_pass  <= 1'b0;
    end else begin
      result_valid <= ctrl.emit_error ||
                      (ctrl.w_pop && (stat.frontier_empty || pend_valid));
      if (cfg_valid) begin
        node_count <= cfg_data;
      end
      if (ctrl.accept) begin
        lk_from     <= item.node_a;
        lk_to       <= item.node_b;
        mode        <= item.walk_mode;
        second_pass <= 1'b0;
      end
      if (ctrl.clear_graph) begin
        deg_vld  <= '0;
        edge_vld <= '0;
      end
      if (ctrl.emit_error) begin
        result <= '{node: '0, level: '0, last: 1'b1, status: gbw_pkg::ST_BAD_START};
      end
      if (ctrl.lk_chk) begin
        lk_from     <= lk_to;
        lk_to       <= lk_from;
        second_pass <= 1'b1;
        if (link_go) begin
          deg_vld[lk_from]  <= 1'b1;
          edge_vld[lk_from] <= 1'b1;
        end
      end
      if (ctrl.w_init) begin
        visited    <= gbw_pkg::NODES'(1) << lk_from;
        head       <= '0;
        tail       <= CW'(1);
        pend_valid <= 1'b0;
      end
      // A node goes out one pop later, once it is known whether it closes the walk.
      if (ctrl.w_pop) begin
        if (stat.frontier_empty) begin
          result <= '{node: cur_node, level: cur_lev, last: 1'b1, status: gbw_pkg::ST_OK};
        end else begin
          result <= '{node: cur_node, level: cur_lev, last: 1'b0, status: gbw_pkg::ST_OK};
          if (mode == gbw_pkg::MODE_DEPTH) begin
            tail <= tail_dec;
          end else begin
            head <= head + CW'(1);
          end
        end
      end
      if (ctrl.w_node) begin
        cur_node   <= front_q[2*NW-1:NW];
        cur_lev    <= front_q[NW-1:0];
        pend_valid <= 1'b1;
        idx        <= '0;
      end
      if (ctrl.w_deg) begin
        deg_r <= deg_vld[cur_node] ? deg_q : '0;
      end
      if (ctrl.w_adj_rd) begin
        idx <= idx + CW'(1);
      end
      if (push_go) begin
        visited[adj_q] <= 1'b1;
        tail           <= tail + CW'(1);
      end
    end
  end

`ifndef SYNTH
  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    tail <= gbw_pkg::NODES_C) else $error("frontier tail past capacity");
  a_pending_at_end: assert property (@(posedge clk) disable iff (rst)
    (ctrl.w_pop && stat.frontier_empty) |-> pend_valid)
    else $error("walk ended with no node to report");
  a_error_single: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit_error |=> (result_valid && result.last))
    else $error("error result not flagged last");
  a_bad_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == gbw_pkg::ST_BAD_START) |-> result.last)
    else $error("bad start result not last");
`endif

endmodule

FILE: design/graph_bfs_dfs_walk.sv
// Undirected graph store with breadth-first and depth-first walks.
// An item (cmd, node_a, node_b, walk_mode) is taken when start is high and
// busy is low. A load edge item adds node_b to the list of node_a and
// node_a to that of node_b, skipping entries already present. A clear item
// empties the graph. A traverse item emits one result per reached node on
// result, each marked by result_valid for exactly one cycle; the final one
// has last set. A start node at or above node_count gives a single result
// with status set. The adjacency memory has one read port, read once per
// entry. Each node's result goes out at the next frontier pop, once its
// adjacency list has been read.
// node_count is written through cfg_valid/cfg_data (cfg_ready is always
// high); the user must write it only while the block is idle, which the
// block itself does not enforce. Reset sets node_count to 64 and empties
// the graph. The receiver cannot stall, so results are never held back.
module graph_bfs_dfs_walk (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  gbw_pkg::item_t            item,
  output gbw_pkg::result_t          result,
  output logic                      result_valid,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [gbw_pkg::CNT_W-1:0] cfg_data
);

  gbw_pkg::ctrl_t ctrl;
  gbw_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  gbw_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .cmd  (item.cmd),
    .stat (stat),
    .ctrl (ctrl),
    .busy (busy)
  );

  gbw_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .ctrl        (ctrl),
    .stat        (stat),
    .result      (result),
    .result_valid(result_valid)
  );

endmodule
